// ===== rtl/core/ptc_pkg.sv =====
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared types and constants of the primitive triple counter: controller
// states and the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ptc_pkg;

   // result field width and saturation value
   localparam int COUNT_BITS = 18;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // result word width (count padded to whole bytes)
   localparam int RSP_DATA_BITS = ((COUNT_BITS + 7) / 8) * 8;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_M_TEST,
      ST_N_TEST,
      ST_GCD,
      ST_DONE
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load;      // take the limit, start at m = 1
      logic m_next;    // advance m and its square
      logic n_init;    // start n at m + 1
      logic gcd_load;  // load gcd operands from m and n
      logic gcd_step;  // one binary gcd step
      logic n_next;    // count the pair if coprime, advance n by two
      logic out_load;  // move the count into the result register
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic m_ok;      // m*m below the limit
      logic n_ok;      // m*m + n*n within the limit
      logic gcd_done;  // both operands odd and equal
      logic out_free;  // result register empty or being drained
   } status_type;

endpackage

// ===== rtl/core/primitive_triple_counter.sv =====
// Throughput: one word at a time; a new limit is taken only in the idle state,
//   once the last count has moved into the result register; one gcd step each cycle.
// Reset: synchronous, clears the controller state and the result valid flag.
// ----------------------------------------------------------------------------
// primitive_triple_counter
// Counts coprime opposite-parity pairs m < n with m*m + n*n within the limit,
// i.e. primitive Pythagorean triples with hypotenuse at most the limit.
// ----------------------------------------------------------------------------
module primitive_triple_counter
   import ptc_pkg::*;
#(
   parameter int LIMIT_BITS = 20
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((LIMIT_BITS + 7) / 8) * 8-1:0] req_tdata,  // limit
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [RSP_DATA_BITS-1:0]              rsp_tdata   // triple_count
);

   cmd_type    cmd;
   status_type status;

   ptc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   ptc_dpath #(
      .LIMIT_BITS (LIMIT_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .limit      (req_tdata[LIMIT_BITS-1:0]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== rtl/core/ptc_ctrl.sv =====
// ----------------------------------------------------------------------------
// ptc_ctrl
// Controller of the triple counter: walks the m loop, the n loop and the gcd
// iterations, and hands the final count to the result register.
// ----------------------------------------------------------------------------
module ptc_ctrl
   import ptc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_M_TEST;
         end
         ST_M_TEST: begin
            state_in = status.m_ok ? ST_N_TEST : ST_DONE;
         end
         ST_N_TEST: begin
            state_in = status.n_ok ? ST_GCD : ST_M_TEST;
         end
         ST_GCD: begin
            if (status.gcd_done) state_in = ST_N_TEST;
         end
         ST_DONE: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_M_TEST: begin
            cmd.n_init = status.m_ok;
         end
         ST_N_TEST: begin
            cmd.gcd_load = status.n_ok;
            cmd.m_next   = !status.n_ok;
         end
         ST_GCD: begin
            cmd.n_next   = status.gcd_done;
            cmd.gcd_step = !status.gcd_done;
         end
         ST_DONE: begin
            cmd.out_load = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ===== rtl/core/ptc_dpath.sv =====
// ----------------------------------------------------------------------------
// ptc_dpath
// Datapath of the triple counter: m and n with incrementally kept squares,
// a one-step binary gcd unit, the saturating pair count and the result
// register.
// ----------------------------------------------------------------------------
module ptc_dpath
   import ptc_pkg::*;
#(
   parameter int LIMIT_BITS = 20
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output status_type               status,
   input  logic [LIMIT_BITS-1:0]    limit,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata
);

   // m and n stay below 2^(ceil(LIMIT_BITS/2)) + 2
   localparam int VAL_BITS = (LIMIT_BITS + 1) / 2 + 1;
   localparam int SQ_BITS  = 2 * VAL_BITS;

   logic [LIMIT_BITS-1:0] lim_ff, lim_in;
   logic [VAL_BITS-1:0]   m_ff, m_in;
   logic [VAL_BITS-1:0]   n_ff, n_in;
   logic [SQ_BITS-1:0]    msq_ff, msq_in;
   logic [SQ_BITS-1:0]    nsq_ff, nsq_in;
   logic [VAL_BITS-1:0]   a_ff, a_in;
   logic [VAL_BITS-1:0]   b_ff, b_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [COUNT_BITS-1:0] rsp_count_ff, rsp_count_in;
   logic                  rsp_tvalid_ff, rsp_tvalid_in;

   logic [SQ_BITS-1:0]    m_step;   // 2m + 1
   logic [SQ_BITS-1:0]    n_step;   // 4n + 4
   logic [SQ_BITS:0]      sq_sum;
   logic                  gcd_one;

   assign m_step = SQ_BITS'({m_ff, 1'b1});
   assign n_step = SQ_BITS'({n_ff, 2'b00}) + SQ_BITS'(4);
   assign sq_sum = {1'b0, msq_ff} + {1'b0, nsq_ff};
   assign gcd_one = (a_ff == VAL_BITS'(1));

   // status to the controller
   always_comb begin
      status.m_ok     = msq_ff < SQ_BITS'(lim_ff);
      status.n_ok     = sq_sum <= (SQ_BITS + 1)'(lim_ff);
      status.gcd_done = a_ff[0] && b_ff[0] && (a_ff == b_ff);
      status.out_free = !rsp_tvalid_ff || rsp_tready;
   end

   // loop counters and squares
   always_comb begin
      lim_in = lim_ff;
      m_in   = m_ff;
      msq_in = msq_ff;
      n_in   = n_ff;
      nsq_in = nsq_ff;
      if (cmd.load) begin
         lim_in = limit;
         m_in   = VAL_BITS'(1);
         msq_in = SQ_BITS'(1);
      end
      if (cmd.m_next) begin
         m_in   = m_ff + VAL_BITS'(1);
         msq_in = msq_ff + m_step;
      end
      if (cmd.n_init) begin
         n_in   = m_ff + VAL_BITS'(1);
         nsq_in = msq_ff + m_step;
      end
      if (cmd.n_next) begin
         n_in   = n_ff + VAL_BITS'(2);
         nsq_in = nsq_ff + n_step;
      end
   end

   // binary gcd step: drop factors of two, else subtract and halve
   always_comb begin
      a_in = a_ff;
      b_in = b_ff;
      if (cmd.gcd_load) begin
         a_in = m_ff;
         b_in = n_ff;
      end else if (cmd.gcd_step) begin
         if (!a_ff[0] || !b_ff[0]) begin
            if (!a_ff[0]) a_in = a_ff >> 1;
            if (!b_ff[0]) b_in = b_ff >> 1;
         end else if (a_ff > b_ff) begin
            a_in = (a_ff - b_ff) >> 1;
         end else begin
            b_in = (b_ff - a_ff) >> 1;
         end
      end
   end

   // saturating pair count
   always_comb begin
      count_in = count_ff;
      if (cmd.load) begin
         count_in = '0;
      end else if (cmd.n_next && gcd_one && (count_ff != COUNT_MAX)) begin
         count_in = count_ff + COUNT_BITS'(1);
      end
   end

   // result register
   always_comb begin
      rsp_count_in  = rsp_count_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      if (cmd.out_load) begin
         rsp_count_in  = count_ff;
         rsp_tvalid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      lim_ff       <= lim_in;
      m_ff         <= m_in;
      msq_ff       <= msq_in;
      n_ff         <= n_in;
      nsq_ff       <= nsq_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      count_ff     <= count_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'(rsp_count_ff);

endmodule

// ===== tb/primitive_triple_counter_tb.sv =====
// ----------------------------------------------------------------------------
// primitive_triple_counter_tb
// Streams limit words into the primitive triple counter and checks every
// count word against a local predictor that enumerates coprime pairs of
// opposite parity with a binary gcd. Both stream sides idle and stall at
// random, with stretches of no idling. Limits are kept small except for a
// few directed extremes, since the block's run time grows with the limit.
// ----------------------------------------------------------------------------
module primitive_triple_counter_tb
   import ptc_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIMIT_BITS    = 20;
   localparam int REQ_DATA_BITS = ((LIMIT_BITS + 7) / 8) * 8;
   localparam int MAX_GAP       = 14;
   localparam int DRAIN_CYCLES  = 20;

   logic                     clock;
   logic                     reset;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata;   // limit
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;   // triple_count

   // expected counts, oldest first
   logic [COUNT_BITS-1:0] pending_counts[$];
   int                    mismatches;
   int                    gap_max;

   primitive_triple_counter #(
      .LIMIT_BITS(LIMIT_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   // 20 ns clock
   initial clock = 1'b0;
   always #10 clock = ~clock;

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------

   // binary gcd, answers only whether the gcd is one
   function automatic bit is_coprime(longint unsigned a, longint unsigned b);
      if (a == 0) return b == 1;
      if (b == 0) return a == 1;
      while (a[0] == 1'b0) a >>= 1;
      while (b[0] == 1'b0) b >>= 1;
      while (a != b) begin
         if (a > b) begin
            a -= b;
            while (a[0] == 1'b0) a >>= 1;
         end else begin
            b -= a;
            while (b[0] == 1'b0) b >>= 1;
         end
      end
      return a == 1;
   endfunction

   function automatic logic [COUNT_BITS-1:0] count_triples(logic [REQ_DATA_BITS-1:0] word);
      longint unsigned lim;
      longint unsigned total;
      longint unsigned rest;
      longint unsigned m;
      longint unsigned n;
      lim   = word[LIMIT_BITS-1:0];
      total = 0;
      // n starts one above m and steps by two, so parity always differs
      for (m = 1; m * m < lim; m++) begin
         rest = lim - m * m;
         for (n = m + 1; n * n <= rest; n += 2) begin
            if (is_coprime(m, n)) total++;
         end
      end
      if (total > COUNT_MAX) total = COUNT_MAX;
      return total[COUNT_BITS-1:0];
   endfunction

   // ------------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------------

   task automatic report_mismatch(input string what, input longint unsigned want,
                                  input longint unsigned got);
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
      mismatches++;
   endtask

   // compare each accepted count word with the oldest expectation
   always @(posedge clock) begin : check_word
      logic [COUNT_BITS-1:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_counts.size() == 0) begin
            $display("[%0t] unexpected count word %0d", $realtime,
                     rsp_tdata[COUNT_BITS-1:0]);
            mismatches++;
         end else begin
            want = pending_counts.pop_front();
            if (rsp_tdata[COUNT_BITS-1:0] !== want)
               report_mismatch("triple_count", want, rsp_tdata[COUNT_BITS-1:0]);
            if (rsp_tdata[RSP_DATA_BITS-1:COUNT_BITS] !== '0)
               report_mismatch("padding", 0, rsp_tdata[RSP_DATA_BITS-1:COUNT_BITS]);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result side: stall a random number of cycles per word
   // ------------------------------------------------------------------------

   initial begin : drive_ready
      int stall;
      rsp_tready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         stall = $urandom_range(0, gap_max);
         if (stall != 0) begin
            // hold ready low until the word shows up, then a little longer
            @(negedge clock) rsp_tready <= 1'b0;
            do @(posedge clock); while (!rsp_tvalid);
            repeat (stall) @(negedge clock);
            rsp_tready <= 1'b1;
         end else begin
            @(negedge clock) rsp_tready <= 1'b1;
         end
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------

   // send one limit word; valid stays high if the next word follows at once
   task automatic send_limit(input logic [LIMIT_BITS-1:0] lim);
      int gap;
      gap = $urandom_range(0, gap_max);
      if (gap != 0) begin
         @(negedge clock) req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_BITS'(lim);
      do @(posedge clock); while (!req_tready);
      pending_counts.push_back(count_triples(REQ_DATA_BITS'(lim)));
   endtask

   // drop valid and hold until every expected count has come back
   task automatic wait_for_drain();
      @(negedge clock) req_tvalid <= 1'b0;
      while (pending_counts.size() != 0) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // zero and tiny limits, where no pair fits
   task automatic test_tiny_limits();
      for (int lim = 0; lim <= 4; lim++) send_limit(LIMIT_BITS'(lim));
   endtask

   // limits on and around the smallest hypotenuses and square values
   task automatic test_boundary_limits();
      send_limit(20'd5);
      send_limit(20'd6);
      send_limit(20'd9);
      send_limit(20'd12);
      send_limit(20'd13);
      send_limit(20'd24);
      send_limit(20'd25);
      send_limit(20'd26);
      send_limit(20'd1023);
      send_limit(20'd1024);
      send_limit(20'd4096);
   endtask

   // the widest limits; slow, so sent only once each
   task automatic test_large_limits();
      send_limit(20'd65535);
      send_limit('1);
   endtask

   // random limits, mostly small, in bursts with and without idling
   task automatic test_random_limits(input int count);
      int pick;
      for (int i = 0; i < count; i++) begin
         if (i % 10 == 0) gap_max = ($urandom_range(0, 2) == 0) ? 0 : MAX_GAP;
         if (i == count / 2) wait_for_drain();
         pick = $urandom_range(0, 99);
         if (pick < 60)
            send_limit(LIMIT_BITS'($urandom_range(0, 1023)));
         else if (pick < 93)
            send_limit(LIMIT_BITS'($urandom_range(1024, 8191)));
         else
            send_limit(LIMIT_BITS'($urandom_range(8192, 32767)));
      end
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------

   initial begin
      mismatches = 0;
      gap_max    = MAX_GAP;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      repeat (5) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      test_tiny_limits();
      test_boundary_limits();
      gap_max = 0;
      test_large_limits();
      gap_max = MAX_GAP;
      test_random_limits(90);

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_counts.size() != 0) begin
         $display("%0d count words never arrived", pending_counts.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("PASS primitive_triple_counter");
      end else begin
         $display("FAIL primitive_triple_counter");
      end
      $finish;
   end

   // stop a hung run
   initial begin
      #800_000_000;
      $display("FAIL primitive_triple_counter");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/ptc_pkg.sv
rtl/core/ptc_ctrl.sv
rtl/core/ptc_dpath.sv
rtl/core/primitive_triple_counter.sv
tb/primitive_triple_counter_tb.sv
